@@ design/wfb_pkg.sv @@
// Shared types, constants and byte functions of the 802.11 MAC frame builder.
package wfb_pkg;

    localparam int unsigned MAX_PAYLOAD  = 1500;
    localparam int unsigned CNT_W        = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned ADDR_W       = 48;
    localparam int unsigned SEQ_W        = 12;
    localparam int unsigned DATA_HDR_LEN = 24;
    localparam int unsigned ACK_HDR_LEN  = 10;
    localparam int unsigned FCS_LEN      = 4;
    localparam int unsigned POS_W        = 5;

    localparam logic [7:0]  FC_DATA      = 8'h08;
    localparam logic [7:0]  FC_ACK       = 8'hD4;
    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] CRC_PRESET   = 32'hFFFFFFFF;

    localparam logic [1:0]  REG_DESTINATION = 2'd0;
    localparam logic [1:0]  REG_SOURCE      = 2'd1;
    localparam logic [1:0]  REG_BSS         = 2'd2;

    typedef enum logic [1:0] {
        CMD_PAYLOAD = 2'd0,
        CMD_EMPTY   = 2'd1,
        CMD_ACK     = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]        command;
        logic [7:0]        payload_byte;
        logic              final_payload;
        logic [ADDR_W-1:0] receiver_address;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
        logic       too_large;
    } t_out_item;

    // One unit of work for the back end: which sections of a frame to send.
    typedef struct packed {
        logic              hdr;
        logic              ack;
        logic              pay;
        logic              fcs;
        logic              too_large;
        logic [7:0]        data;
        logic [ADDR_W-1:0] ra;
    } t_job;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Byte k of an address, most significant byte first.
    function automatic logic [7:0] addr_byte(input logic [ADDR_W-1:0] a, input logic [2:0] k);
        logic [7:0] b;
        unique case (k)
            3'd0:    b = a[47:40];
            3'd1:    b = a[39:32];
            3'd2:    b = a[31:24];
            3'd3:    b = a[23:16];
            3'd4:    b = a[15:8];
            3'd5:    b = a[7:0];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] data_hdr_byte(input logic [POS_W-1:0] pos,
                                                 input logic [ADDR_W-1:0] dst,
                                                 input logic [ADDR_W-1:0] src,
                                                 input logic [ADDR_W-1:0] bss,
                                                 input logic [SEQ_W-1:0] seq);
        logic [7:0]  b;
        logic [15:0] sc;
        sc = {seq, 4'd0};
        unique case (pos) inside
            5'd0:           b = FC_DATA;
            [5'd4:5'd9]:    b = addr_byte(dst, 3'(pos - 5'd4));
            [5'd10:5'd15]:  b = addr_byte(src, 3'(pos - 5'd10));
            [5'd16:5'd21]:  b = addr_byte(bss, 3'(pos - 5'd16));
            5'd22:          b = sc[7:0];
            5'd23:          b = sc[15:8];
            default:        b = 8'd0;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] ack_hdr_byte(input logic [POS_W-1:0] pos,
                                                input logic [ADDR_W-1:0] ra);
        logic [7:0] b;
        unique case (pos) inside
            5'd0:        b = FC_ACK;
            [5'd4:5'd9]: b = addr_byte(ra, 3'(pos - 5'd4));
            default:     b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

@@ design/wlan_mac_frame_builder_unit.sv @@
// Top level of the 802.11 MAC frame builder: front end, job queue and byte sequencer.
// Emits one frame byte per cycle when the output is not stalled. Payload bytes inside
// a frame stream through at one byte per cycle; the first byte of a data frame follows
// the 24 header bytes, the final one is followed by the 4 FCS bytes, an empty data frame
// is 28 bytes long and an ack frame 14. The back-end sequencer sends one byte per cycle
// while the output is not stalled; a two-entry job queue lets input transfers continue
// while a header or FCS burst is still being sent. Address registers should be written
// only while no frame is in progress.
module wlan_mac_frame_builder_unit
    import wfb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item
);

    logic push, pop, q_full, q_empty;
    t_job job, head;

    assign o_in_stall = q_full;

    wfb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_item (i_in_item),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_job     (job)
    );

    wfb_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (job),
        .i_pop  (pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_head (head)
    );

    wfb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_q_empty  (q_empty),
        .i_head     (head),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

endmodule

@@ design/wfb_front.sv @@
// Front end: accepts input items, tracks frame state and turns each item that has work into a job.
module wfb_front
    import wfb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    input  logic     i_q_full,
    output logic     o_push,
    output t_job     o_job
);

    logic             r_in_frame, n_in_frame;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;

    logic             accept;
    logic [CNT_W-1:0] eff_count;
    logic             eff_ovf;
    logic             drop;
    t_job             job;
    logic             has_work;

    assign accept    = i_in_valid && !i_q_full;
    assign eff_count = r_in_frame ? r_count : '0;
    assign eff_ovf   = r_in_frame && r_ovf;
    assign drop      = (eff_count >= CNT_W'(MAX_PAYLOAD));

    always_comb begin
        job           = '0;
        job.data      = i_in_item.payload_byte;
        job.ra        = i_in_item.receiver_address;
        n_in_frame    = r_in_frame;
        n_count       = r_count;
        n_ovf         = r_ovf;
        unique case (t_cmd'(i_in_item.command))
            CMD_PAYLOAD: begin
                job.hdr       = !r_in_frame;
                job.pay       = !drop;
                job.fcs       = i_in_item.final_payload;
                job.too_large = eff_ovf || drop;
                if (i_in_item.final_payload) begin
                    n_in_frame = 1'b0;
                    n_count    = '0;
                    n_ovf      = 1'b0;
                end else begin
                    n_in_frame = 1'b1;
                    n_count    = drop ? eff_count : eff_count + 1'b1;
                    n_ovf      = eff_ovf || drop;
                end
            end
            CMD_EMPTY: begin
                job.hdr = !r_in_frame;
                job.fcs = !r_in_frame;
            end
            CMD_ACK: begin
                job.ack = !r_in_frame;
                job.fcs = !r_in_frame;
            end
            default: ;
        endcase
    end

    // A dropped byte that does not close its frame produces no transfer at all.
    assign has_work = job.hdr || job.ack || job.pay || job.fcs;
    assign o_push   = accept && has_work;
    assign o_job    = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
            r_ovf      <= 1'b0;
        end else if (accept) begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_ovf      <= n_ovf;
        end
    end

endmodule

@@ design/wfb_queue.sv @@
// Two-entry job queue between the front end and the back end.
module wfb_queue
    import wfb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job written into a full queue");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job taken from an empty queue");
`endif

endmodule

@@ design/wfb_back.sv @@
// Back end: sequences header, payload and FCS bytes of each job into the output register.
module wfb_back
    import wfb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  logic              i_q_empty,
    input  t_job              i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item
);

    typedef enum logic [3:0] {
        BS_START = 4'b0001,
        BS_HEAD  = 4'b0010,
        BS_BODY  = 4'b0100,
        BS_FCS   = 4'b1000
    } t_bstate;

    logic [ADDR_W-1:0] r_dst, r_src, r_bss;
    logic [SEQ_W-1:0]  r_seq;
    logic [31:0]       r_crc, n_crc;
    t_bstate           r_state, n_state, cur;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_out_valid;
    t_out_item         r_out, n_out;

    logic              fire;
    logic              job_done;
    logic              seq_step;
    logic [POS_W-1:0]  head_last;
    logic [31:0]       fcs;

    assign fire      = !i_q_empty && (!r_out_valid || !i_out_stall);
    assign head_last = i_head.ack ? POS_W'(ACK_HDR_LEN - 1) : POS_W'(DATA_HDR_LEN - 1);
    assign fcs       = ~r_crc;

    // At the start of a job the first section comes straight from the queue head.
    always_comb begin
        if (r_state == BS_START) begin
            if (i_head.hdr || i_head.ack) begin
                cur = BS_HEAD;
            end else if (i_head.pay) begin
                cur = BS_BODY;
            end else begin
                cur = BS_FCS;
            end
        end else begin
            cur = r_state;
        end
    end

    always_comb begin
        n_out    = '0;
        n_crc    = r_crc;
        n_state  = cur;
        n_pos    = r_pos;
        job_done = 1'b0;
        seq_step = 1'b0;
        unique case (cur)
            BS_HEAD: begin
                n_out.frame_byte = i_head.ack ? ack_hdr_byte(r_pos, i_head.ra)
                                              : data_hdr_byte(r_pos, r_dst, r_src, r_bss, r_seq);
                n_crc = crc_byte((r_pos == '0) ? CRC_PRESET : r_crc, n_out.frame_byte);
                if (r_pos == head_last) begin
                    seq_step = !i_head.ack;
                    n_pos    = '0;
                    if (i_head.pay) begin
                        n_state = BS_BODY;
                    end else if (i_head.fcs) begin
                        n_state = BS_FCS;
                    end else begin
                        job_done = 1'b1;
                    end
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            BS_BODY: begin
                n_out.frame_byte = i_head.data;
                n_crc            = crc_byte(r_crc, i_head.data);
                n_pos            = '0;
                if (i_head.fcs) begin
                    n_state = BS_FCS;
                end else begin
                    job_done = 1'b1;
                end
            end
            BS_FCS: begin
                unique case (r_pos[1:0])
                    2'd0:    n_out.frame_byte = fcs[7:0];
                    2'd1:    n_out.frame_byte = fcs[15:8];
                    2'd2:    n_out.frame_byte = fcs[23:16];
                    default: n_out.frame_byte = fcs[31:24];
                endcase
                if (r_pos == POS_W'(FCS_LEN - 1)) begin
                    n_out.end_of_frame = 1'b1;
                    n_out.too_large    = i_head.too_large;
                    n_crc              = CRC_PRESET;
                    n_pos              = '0;
                    job_done           = 1'b1;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            default: ;
        endcase
        if (job_done) begin
            n_state = BS_START;
        end
    end

    assign o_pop       = fire && job_done;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst <= '0;
            r_src <= '0;
            r_bss <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DESTINATION: r_dst <= i_cfg_data;
                REG_SOURCE:      r_src <= i_cfg_data;
                REG_BSS:         r_bss <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_START;
            r_pos       <= '0;
            r_crc       <= CRC_PRESET;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_out_valid <= 1'b1;
            if (seq_step) begin
                r_seq <= r_seq + 1'b1;
            end
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

`ifndef NO_ASSERTIONS
    a_fcs_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_FCS) |-> (r_pos < POS_W'(FCS_LEN)))
        else $error("FCS byte position out of range");
    a_too_large_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.too_large) |-> r_out.end_of_frame)
        else $error("oversize flag away from the end of a frame");
    a_start_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == BS_START) && (r_pos == '0))
        else $error("sequencer did not return to the start of a job");
`endif

endmodule

@@ tb/sv/wlan_mac_frame_builder_unit_chk.sv @@
// Scoreboard of the frame builder: predicts the byte stream of each input transfer and checks it.
`timescale 1ns / 100ps
module wlan_mac_frame_builder_unit_chk
    import wfb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in_item          i_in_item,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out_item         i_out_item,
    output int                o_errors,
    output int                o_pending
);

    logic [ADDR_W-1:0] dst_addr;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] bss_addr;
    logic              frame_open;
    logic [SEQ_W-1:0]  seq_num;
    logic [31:0]       fcs_acc;
    int                payload_len;
    logic              payload_dropped;
    t_out_item         bytes_due[$];
    t_out_item         want;
    int                error_count = 0;

    // Reflected CRC-32, one message bit at a time, least significant bit first.
    function automatic logic [31:0] fcs_next(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = acc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic eof, input logic tl);
        t_out_item r;
        r.frame_byte   = b;
        r.end_of_frame = eof;
        r.too_large    = tl;
        bytes_due.push_back(r);
    endfunction

    function automatic void push_covered(input logic [7:0] b);
        fcs_acc = fcs_next(fcs_acc, b);
        push_byte(b, 1'b0, 1'b0);
    endfunction

    function automatic void push_address(input logic [ADDR_W-1:0] a);
        for (int k = 5; k >= 0; k--) begin
            push_covered(a[8*k +: 8]);
        end
    endfunction

    function automatic void push_data_header();
        logic [15:0] seq_ctrl;
        seq_ctrl = {seq_num, 4'h0};
        fcs_acc  = CRC_PRESET;
        push_covered(FC_DATA);
        push_covered(8'h00);
        push_covered(8'h00);
        push_covered(8'h00);
        push_address(dst_addr);
        push_address(src_addr);
        push_address(bss_addr);
        push_covered(seq_ctrl[7:0]);
        push_covered(seq_ctrl[15:8]);
        seq_num = seq_num + 1'b1;
    endfunction

    // The FCS goes out least significant byte first; the last byte closes the frame.
    function automatic void push_fcs(input logic tl);
        logic [31:0] fcs;
        fcs = ~fcs_acc;
        push_byte(fcs[7:0], 1'b0, 1'b0);
        push_byte(fcs[15:8], 1'b0, 1'b0);
        push_byte(fcs[23:16], 1'b0, 1'b0);
        push_byte(fcs[31:24], 1'b1, tl);
        fcs_acc = CRC_PRESET;
    endfunction

    function automatic void predict_frame_bytes(input t_in_item it);
        case (t_cmd'(it.command))
            CMD_PAYLOAD: begin
                if (!frame_open) begin
                    push_data_header();
                    frame_open      = 1'b1;
                    payload_len     = 0;
                    payload_dropped = 1'b0;
                end
                if (payload_len < int'(MAX_PAYLOAD)) begin
                    push_covered(it.payload_byte);
                    payload_len++;
                end else begin
                    payload_dropped = 1'b1;
                end
                if (it.final_payload) begin
                    push_fcs(payload_dropped);
                    frame_open      = 1'b0;
                    payload_len     = 0;
                    payload_dropped = 1'b0;
                end
            end
            CMD_EMPTY: begin
                if (!frame_open) begin
                    push_data_header();
                    push_fcs(1'b0);
                end
            end
            CMD_ACK: begin
                if (!frame_open) begin
                    fcs_acc = CRC_PRESET;
                    push_covered(FC_ACK);
                    push_covered(8'h00);
                    push_covered(8'h00);
                    push_covered(8'h00);
                    push_address(it.receiver_address);
                    push_fcs(1'b0);
                end
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dst_addr        = '0;
            src_addr        = '0;
            bss_addr        = '0;
            frame_open      = 1'b0;
            seq_num         = '0;
            fcs_acc         = CRC_PRESET;
            payload_len     = 0;
            payload_dropped = 1'b0;
            bytes_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DESTINATION: dst_addr = i_cfg_data;
                    REG_SOURCE:      src_addr = i_cfg_data;
                    REG_BSS:         bss_addr = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // The input side is handled first in case a byte leaves in the cycle it arrives.
            if (i_in_valid && !i_in_stall) begin
                predict_frame_bytes(i_in_item);
            end
            if (i_out_valid && !i_out_stall) begin
                if (bytes_due.size() == 0) begin
                    $error("unexpected transfer: frame_byte %h end_of_frame %b too_large %b",
                           i_out_item.frame_byte, i_out_item.end_of_frame,
                           i_out_item.too_large);
                    error_count++;
                end else begin
                    want = bytes_due.pop_front();
                    if (i_out_item.frame_byte !== want.frame_byte) begin
                        $error("frame_byte: expected %h, actual %h",
                               want.frame_byte, i_out_item.frame_byte);
                        error_count++;
                    end
                    if (i_out_item.end_of_frame !== want.end_of_frame) begin
                        $error("end_of_frame: expected %b, actual %b",
                               want.end_of_frame, i_out_item.end_of_frame);
                        error_count++;
                    end
                    if (i_out_item.too_large !== want.too_large) begin
                        $error("too_large: expected %b, actual %b",
                               want.too_large, i_out_item.too_large);
                        error_count++;
                    end
                end
            end
        end
        o_pending <= bytes_due.size();
        o_errors  <= error_count;
    end

endmodule

@@ tb/sv/wlan_mac_frame_builder_unit_tb.sv @@
// Testbench top of the frame builder: clock, reset, stimulus, backpressure and the verdict.
`timescale 1ns / 100ps
module wlan_mac_frame_builder_unit_tb;
    import wfb_pkg::*;

    localparam int unsigned LIMIT_CYCLES  = 2_000_000;
    localparam int          SETTLE_CYCLES = 64;
    localparam int          IDLE_MAX      = 12;
    localparam logic [1:0]  REG_INVALID   = 2'd3;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [ADDR_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_stall;
    t_in_item          in_item;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out_item         out_item;

    int                chk_errors;
    int                chk_pending;
    int                in_gap_max;
    int                out_stall_max = IDLE_MAX;
    int                out_hold = 0;
    logic              out_taken = 1'b0;
    logic              frame_open;
    int unsigned       cycle_count = 0;

    wlan_mac_frame_builder_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    wlan_mac_frame_builder_unit_chk chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("wlan_mac_frame_builder_unit regression: fail");
            $finish;
        end
    end

    // After each output transfer a fresh stall length is drawn for the next byte.
    always @(posedge clk) begin
        out_taken <= out_valid && !out_stall;
    end

    always @(negedge clk) begin
        if (out_taken) begin
            out_hold = $urandom_range(0, out_stall_max);
        end
        if (out_valid && out_hold > 0) begin
            out_stall <= 1'b1;
            out_hold--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] w;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        w    = {$urandom, $urandom};
        if (pick == 0) begin
            w = '0;
        end else if (pick == 1) begin
            w = '1;
        end
        return w[ADDR_W-1:0];
    endfunction

    task automatic send_item(input t_cmd cmd, input logic [7:0] pbyte, input logic fin,
                             input logic [ADDR_W-1:0] ra);
        t_in_item it;
        int       gap;
        it.command          = cmd;
        it.payload_byte     = pbyte;
        it.final_payload    = fin;
        it.receiver_address = ra;
        gap = $urandom_range(0, in_gap_max);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (cmd == CMD_PAYLOAD) begin
            frame_open = !fin;
        end
    endtask

    // Commands that the block ignores: empty and ack only count as noise inside a frame.
    task automatic send_noise();
        t_cmd cmd;
        cmd = CMD_UNUSED;
        if (frame_open) begin
            case ($urandom_range(0, 2))
                0:       cmd = CMD_EMPTY;
                1:       cmd = CMD_ACK;
                default: cmd = CMD_UNUSED;
            endcase
        end
        send_item(cmd, 8'($urandom), 1'($urandom), rand_addr());
    endtask

    task automatic send_frame(input int len, input logic noisy);
        for (int n = 1; n <= len; n++) begin
            if (noisy && $urandom_range(0, 7) == 0) begin
                send_noise();
            end
            send_item(CMD_PAYLOAD, 8'($urandom), n == len, rand_addr());
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (chk_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [ADDR_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_traffic(input int n_items);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
                send_frame(len, 1'b1);
                sent += len;
            end else if (pick < 75) begin
                send_item(CMD_EMPTY, 8'($urandom), 1'($urandom), rand_addr());
                sent++;
            end else if (pick < 90) begin
                send_item(CMD_ACK, 8'($urandom), 1'($urandom), rand_addr());
                sent++;
            end else begin
                send_noise();
            end
            if ($urandom_range(0, 19) == 0) begin
                wait_idle();
            end
        end
    endtask

    initial begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_DESTINATION;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_item    = '0;
        in_gap_max = IDLE_MAX;
        frame_open = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part with the addresses still at their reset values.
        send_item(CMD_ACK, 8'h00, 1'b0, '0);
        send_item(CMD_ACK, 8'hFF, 1'b1, '1);
        send_item(CMD_EMPTY, 8'h00, 1'b0, '0);
        send_item(CMD_UNUSED, 8'hFF, 1'b1, '1);
        send_item(CMD_PAYLOAD, 8'h00, 1'b1, '0);
        send_item(CMD_PAYLOAD, 8'hFF, 1'b0, '1);
        send_item(CMD_EMPTY, 8'h3C, 1'b1, '0);
        send_item(CMD_ACK, 8'hC3, 1'b0, '1);
        send_item(CMD_UNUSED, 8'h00, 1'b1, '0);
        send_item(CMD_PAYLOAD, 8'hA5, 1'b0, '0);
        send_item(CMD_PAYLOAD, 8'h5A, 1'b1, '1);
        send_item(CMD_EMPTY, 8'hFF, 1'b1, '1);
        wait_idle();

        write_reg(REG_DESTINATION, '1);
        write_reg(REG_SOURCE, '1);
        write_reg(REG_BSS, '1);
        write_reg(REG_INVALID, rand_addr());
        send_item(CMD_EMPTY, 8'h00, 1'b0, '0);
        send_frame(2, 1'b0);
        random_traffic(30);
        wait_idle();

        write_reg(REG_DESTINATION, rand_addr());
        write_reg(REG_SOURCE, rand_addr());
        write_reg(REG_BSS, rand_addr());
        write_reg(REG_INVALID, '1);
        in_gap_max    = $urandom_range(1, IDLE_MAX);
        out_stall_max = $urandom_range(1, IDLE_MAX);
        random_traffic(30);
        wait_idle();

        // A stretch with no idling on either side.
        in_gap_max    = 0;
        out_stall_max = 0;
        write_reg(REG_DESTINATION, 48'h0123_4567_89AB);
        write_reg(REG_SOURCE, 48'hFEDC_BA98_7654);
        write_reg(REG_BSS, 48'hAAAA_5555_AAAA);
        random_traffic(30);
        wait_idle();

        if (chk_errors == 0) begin
            $display("wlan_mac_frame_builder_unit regression: pass");
        end else begin
            $display("wlan_mac_frame_builder_unit regression: fail");
        end
        $finish;
    end

endmodule
